// File: src/signed_128bit_alu_core_assert.svh
// Assertion macros for the signed ALU core.
// They sample on clk and stay quiet while rst_n is low.
`ifndef SIGNED_128BIT_ALU_CORE_ASSERT_SVH
`define SIGNED_128BIT_ALU_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define S128A_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define S128A_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/s128a_pkg.sv
// ----------------------------------------------------------------------------
// s128a_pkg
// Operation codes and the control group that travels down the ALU pipeline.
// ----------------------------------------------------------------------------
package s128a_pkg;

    typedef logic [1:0] func_t;

    localparam func_t FUNC_ADD = 2'd0;
    localparam func_t FUNC_SUB = 2'd1;
    localparam func_t FUNC_MUL = 2'd2;
    localparam func_t FUNC_DIV = 2'd3;

    // Port width of every operand and result half.
    localparam int PORT_WIDTH = 64;

    // Control that moves with each beat through the pipeline.
    typedef struct packed {
        logic  valid;
        func_t func;
        logic  less;
        logic  equal;
        logic  neg_q;
        logic  div_zero;
    } ctl_t;

endpackage

// File: src/s128a_prep.sv
// ----------------------------------------------------------------------------
// s128a_prep
// First stage: compares the operands, forms their magnitudes for the divider
// and computes the sum or difference.
// ----------------------------------------------------------------------------
module s128a_prep #(
    parameter int W = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  s128a_pkg::func_t func,
    input  logic [W-1:0]     a,
    input  logic [W-1:0]     b,
    output s128a_pkg::ctl_t  ctl,
    output logic [W-1:0]     a_out,
    output logic [W-1:0]     b_out,
    output logic [W-1:0]     abs_a,
    output logic [W-1:0]     abs_b,
    output logic [W-1:0]     alt
);
    import s128a_pkg::*;

    ctl_t         ctl_reg;
    ctl_t         ctl_next;
    logic [W-1:0] a_reg;
    logic [W-1:0] b_reg;
    logic [W-1:0] abs_a_reg;
    logic [W-1:0] abs_a_next;
    logic [W-1:0] abs_b_reg;
    logic [W-1:0] abs_b_next;
    logic [W-1:0] alt_reg;
    logic [W-1:0] alt_next;

    // Flags, magnitudes and the add or subtract result.
    always_comb
    begin
        ctl_next.valid    = in_valid;
        ctl_next.func     = func;
        ctl_next.less     = $signed(a) < $signed(b);
        ctl_next.equal    = (a == b);
        ctl_next.neg_q    = a[W-1] ^ b[W-1];
        ctl_next.div_zero = (b == '0);
        abs_a_next = a[W-1] ? (~a) + W'(1) : a;
        abs_b_next = b[W-1] ? (~b) + W'(1) : b;
        alt_next   = (func == FUNC_SUB) ? a - b : a + b;
    end

    // The control group resets to an empty slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= a;
            b_reg     <= b;
            abs_a_reg <= abs_a_next;
            abs_b_reg <= abs_b_next;
            alt_reg   <= alt_next;
        end
    end

    assign ctl   = ctl_reg;
    assign a_out = a_reg;
    assign b_out = b_reg;
    assign abs_a = abs_a_reg;
    assign abs_b = abs_b_reg;
    assign alt   = alt_reg;

endmodule

// File: src/s128a_mul.sv
// ----------------------------------------------------------------------------
// s128a_mul
// Low half of a W by W product in three stages: quarter-width partial
// products, grouping by weight, final sum.
// ----------------------------------------------------------------------------
module s128a_mul #(
    parameter int W = 128
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] prod
);
    localparam int K  = (W + 3) / 4;
    localparam int PW = 4 * K;

    logic [PW-1:0]  ax;
    logic [PW-1:0]  bx;
    logic [K-1:0]   a0, a1, a2, a3;
    logic [K-1:0]   b0, b1, b2, b3;

    logic [2*K-1:0] p00_reg, p01_reg, p10_reg, p02_reg, p11_reg;
    logic [2*K-1:0] p20_reg, p03_reg, p12_reg, p21_reg, p30_reg;
    logic [2*K-1:0] g0_reg;
    logic [2*K:0]   g1_reg;
    logic [2*K+1:0] g2_reg;
    logic [K-1:0]   g3_reg;
    logic [W-1:0]   prod_reg;
    logic [PW-1:0]  sum_next;

    // Split the operands into quarter chunks.
    always_comb
    begin
        ax = PW'(a);
        bx = PW'(b);
        a0 = ax[0*K +: K];
        a1 = ax[1*K +: K];
        a2 = ax[2*K +: K];
        a3 = ax[3*K +: K];
        b0 = bx[0*K +: K];
        b1 = bx[1*K +: K];
        b2 = bx[2*K +: K];
        b3 = bx[3*K +: K];
    end

    // Stage one: partial products that reach the low W bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= (2*K)'(a0) * (2*K)'(b0);
            p01_reg <= (2*K)'(a0) * (2*K)'(b1);
            p10_reg <= (2*K)'(a1) * (2*K)'(b0);
            p02_reg <= (2*K)'(a0) * (2*K)'(b2);
            p11_reg <= (2*K)'(a1) * (2*K)'(b1);
            p20_reg <= (2*K)'(a2) * (2*K)'(b0);
            p03_reg <= (2*K)'(a0) * (2*K)'(b3);
            p12_reg <= (2*K)'(a1) * (2*K)'(b2);
            p21_reg <= (2*K)'(a2) * (2*K)'(b1);
            p30_reg <= (2*K)'(a3) * (2*K)'(b0);
        end
    end

    // Stage two: sum products of equal weight.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g0_reg <= p00_reg;
            g1_reg <= (2*K+1)'(p01_reg) + (2*K+1)'(p10_reg);
            g2_reg <= (2*K+2)'(p02_reg) + (2*K+2)'(p11_reg) + (2*K+2)'(p20_reg);
            g3_reg <= p03_reg[K-1:0] + p12_reg[K-1:0] + p21_reg[K-1:0]
                      + p30_reg[K-1:0];
        end
    end

    // Stage three: shift the groups into place and add.
    assign sum_next = PW'(g0_reg) + (PW'(g1_reg) << K) + (PW'(g2_reg) << (2*K))
                      + (PW'(g3_reg) << (3*K));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= sum_next[W-1:0];
        end
    end

    assign prod = prod_reg;

endmodule

// File: src/s128a_div_stage.sv
// ----------------------------------------------------------------------------
// s128a_div_stage
// One step of restoring division on magnitudes: one quotient bit per stage.
// Also carries the other operation's result and the control group.
// ----------------------------------------------------------------------------
module s128a_div_stage #(
    parameter int W = 128
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  s128a_pkg::ctl_t ctl_in,
    input  logic [W-1:0]    rem_in,
    input  logic [W-1:0]    nq_in,
    input  logic [W-1:0]    dvs_in,
    input  logic [W-1:0]    alt_in,
    output s128a_pkg::ctl_t ctl_out,
    output logic [W-1:0]    rem_out,
    output logic [W-1:0]    nq_out,
    output logic [W-1:0]    dvs_out,
    output logic [W-1:0]    alt_out
);
    import s128a_pkg::*;

    ctl_t         ctl_reg;
    logic [W-1:0] rem_reg;
    logic [W-1:0] rem_next;
    logic [W-1:0] nq_reg;
    logic [W-1:0] nq_next;
    logic [W-1:0] dvs_reg;
    logic [W-1:0] alt_reg;
    logic [W:0]   shifted;
    logic [W+1:0] diff;
    logic         ge;

    // Bring down the next dividend bit and try the subtraction.
    always_comb
    begin
        shifted  = {rem_in, nq_in[W-1]};
        diff     = {1'b0, shifted} - {2'b00, dvs_in};
        ge       = !diff[W+1];
        rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
        nq_next  = {nq_in[W-2:0], ge};
    end

    // The control group resets to an empty slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
            dvs_reg <= dvs_in;
            alt_reg <= alt_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign nq_out  = nq_reg;
    assign dvs_out = dvs_reg;
    assign alt_out = alt_reg;

endmodule

// File: src/signed_128bit_alu_core.sv
// ----------------------------------------------------------------------------
// signed_128bit_alu_core
// Pipelined signed add, subtract, multiply and divide on 2*HALF_WIDTH-bit
// operands, with less-than and equal flags.
// ----------------------------------------------------------------------------
//  Channel  Handshake           Beat fields
//  input    in_valid/in_stall   func, a_high, a_low, b_high, b_low
//  output   out_valid/out_stall res_high, res_low, a_less, a_equal, divide_error
//
// One beat can enter every cycle unless in_stall is high; the divider resolves one
// quotient bit per stage.
// The multiplier runs in three stages beside the first divider stages.
// Reset clears the control groups and the output valid bit only; no clearing pass is needed.
// The whole pipeline holds while a result waits under out_stall; it keeps
// moving, bubbles included, whenever the output register is free.
// ----------------------------------------------------------------------------
module signed_128bit_alu_core #(
    parameter int HALF_WIDTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  s128a_pkg::func_t                    func,
    input  logic signed [s128a_pkg::PORT_WIDTH-1:0] a_high,
    input  logic [s128a_pkg::PORT_WIDTH-1:0]    a_low,
    input  logic signed [s128a_pkg::PORT_WIDTH-1:0] b_high,
    input  logic [s128a_pkg::PORT_WIDTH-1:0]    b_low,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [s128a_pkg::PORT_WIDTH-1:0] res_high,
    output logic [s128a_pkg::PORT_WIDTH-1:0]    res_low,
    output logic                                a_less,
    output logic                                a_equal,
    output logic                                divide_error
);
    import s128a_pkg::*;

    `include "signed_128bit_alu_core_assert.svh"

    localparam int W       = 2 * HALF_WIDTH;
    localparam int MUL_LAT = 3;

    logic         en;
    logic [W-1:0] a_op;
    logic [W-1:0] b_op;
    logic [W-1:0] a_st;
    logic [W-1:0] b_st;
    logic [W-1:0] mul_res;

    ctl_t         ctl_s [0:W];
    logic [W-1:0] rem_s [0:W];
    logic [W-1:0] nq_s  [0:W];
    logic [W-1:0] dvs_s [0:W];
    logic [W-1:0] alt_s [0:W];

    logic         out_valid_reg;
    logic [W-1:0] res_reg;
    logic [W-1:0] res_next;
    logic [W-1:0] quo;
    logic         less_reg;
    logic         equal_reg;
    logic         err_reg;
    logic         err_next;

    // The pipeline moves unless a finished beat is being held.
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // Assemble the operands from their used half bits.
    assign a_op = {a_high[HALF_WIDTH-1:0], a_low[HALF_WIDTH-1:0]};
    assign b_op = {b_high[HALF_WIDTH-1:0], b_low[HALF_WIDTH-1:0]};

    s128a_prep #(.W(W)) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .func     (func),
        .a        (a_op),
        .b        (b_op),
        .ctl      (ctl_s[0]),
        .a_out    (a_st),
        .b_out    (b_st),
        .abs_a    (nq_s[0]),
        .abs_b    (dvs_s[0]),
        .alt      (alt_s[0])
    );

    assign rem_s[0] = '0;

    s128a_mul #(.W(W)) u_mul (
        .clk  (clk),
        .en   (en),
        .a    (a_st),
        .b    (b_st),
        .prod (mul_res)
    );

    // Divider chain; the product joins the carried result where it is ready.
    for (genvar j = 0; j < W; j++)
    begin : g_div
        logic [W-1:0] alt_in;

        if (j == MUL_LAT)
        begin : g_mul_join
            assign alt_in = (ctl_s[j].func == FUNC_MUL) ? mul_res : alt_s[j];
        end
        else
        begin : g_pass
            assign alt_in = alt_s[j];
        end

        s128a_div_stage #(.W(W)) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (ctl_s[j]),
            .rem_in  (rem_s[j]),
            .nq_in   (nq_s[j]),
            .dvs_in  (dvs_s[j]),
            .alt_in  (alt_in),
            .ctl_out (ctl_s[j+1]),
            .rem_out (rem_s[j+1]),
            .nq_out  (nq_s[j+1]),
            .dvs_out (dvs_s[j+1]),
            .alt_out (alt_s[j+1])
        );
    end

    // Sign the quotient and pick the result.
    always_comb
    begin
        quo      = ctl_s[W].neg_q ? (~nq_s[W]) + W'(1) : nq_s[W];
        err_next = (ctl_s[W].func == FUNC_DIV) && ctl_s[W].div_zero;
        if (ctl_s[W].func == FUNC_DIV)
        begin
            res_next = ctl_s[W].div_zero ? '0 : quo;
        end
        else
        begin
            res_next = alt_s[W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ctl_s[W].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg   <= res_next;
            less_reg  <= ctl_s[W].less;
            equal_reg <= ctl_s[W].equal;
            err_reg   <= err_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign res_high     = PORT_WIDTH'(signed'(res_reg[W-1:HALF_WIDTH]));
    assign res_low      = PORT_WIDTH'(res_reg[HALF_WIDTH-1:0]);
    assign a_less       = less_reg;
    assign a_equal      = equal_reg;
    assign divide_error = err_reg;

    // A divide by a zero divisor always yields a zero result.
    `S128A_ASSERT_SAME(a_div_zero_result, out_valid && divide_error,
        res_high == '0 && res_low == '0, "divide error with nonzero result")

    // Equal operands are never reported as less.
    `S128A_ASSERT_SAME(a_flags_exclusive, out_valid && a_equal, !a_less,
        "equal and less flags both set")

    // A held result stays presented.
    `S128A_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid,
        "stalled result dropped")

endmodule

// File: tb/sv/signed_128bit_alu_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_128bit_alu_core_tb
// Drives operand pairs through the signed ALU under random gaps on both
// channels and checks every result beat against a 128-bit arithmetic
// predictor: wrapped add, subtract and multiply, truncating divide, the
// divide-by-zero flag and the signed compare flags.
// ----------------------------------------------------------------------------
module signed_128bit_alu_core_tb;
    import s128a_pkg::*;

    localparam int HW = 64;

    typedef struct packed {
        logic [63:0] res_high;
        logic [63:0] res_low;
        logic        less;
        logic        equal;
        logic        div_err;
    } alu_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    func_t func;
    logic signed [63:0] a_high;
    logic [63:0] a_low;
    logic signed [63:0] b_high;
    logic [63:0] b_low;
    logic out_valid;
    logic out_stall;
    logic signed [63:0] res_high;
    logic [63:0] res_low;
    logic a_less;
    logic a_equal;
    logic divide_error;

    alu_result_t pending_results[$];
    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int beats_sent;
    int beats_checked;
    int div_zero_seen;

    signed_128bit_alu_core #(.HALF_WIDTH(HW)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .a_high(a_high), .a_low(a_low),
        .b_high(b_high), .b_low(b_low),
        .out_valid(out_valid), .out_stall(out_stall),
        .res_high(res_high), .res_low(res_low),
        .a_less(a_less), .a_equal(a_equal), .divide_error(divide_error)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Predict one result beat from one operand beat.
    function automatic alu_result_t predict_alu(func_t op, logic [63:0] ah, logic [63:0] al,
                                                logic [63:0] bh, logic [63:0] bl);
        logic signed [127:0] opa;
        logic signed [127:0] opb;
        logic [127:0] mag_a;
        logic [127:0] mag_b;
        logic [127:0] quot;
        logic [127:0] res;
        alu_result_t r;
        opa = {ah, al};
        opb = {bh, bl};
        res = '0;
        r.div_err = 1'b0;
        case (op)
            FUNC_ADD: res = opa + opb;
            FUNC_SUB: res = opa - opb;
            FUNC_MUL: res = opa * opb;
            default:
            begin
                if (opb == 0)
                    r.div_err = 1'b1;
                else
                begin
                    // Unsigned divide on magnitudes keeps the overflow case wrapping.
                    mag_a = opa[127] ? -opa : opa;
                    mag_b = opb[127] ? -opb : opb;
                    quot = mag_a / mag_b;
                    res = (opa[127] != opb[127]) ? -quot : quot;
                end
            end
        endcase
        r.res_high = res[127:64];
        r.res_low = res[63:0];
        r.less = opa < opb;
        r.equal = opa == opb;
        return r;
    endfunction

    // Send one operand beat and queue its expected result.
    task automatic send_beat(func_t op, logic [63:0] ah, logic [63:0] al,
                             logic [63:0] bh, logic [63:0] bl);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= op;
        a_high <= ah;
        a_low <= al;
        b_high <= bh;
        b_low <= bl;
        pending_results.push_back(predict_alu(op, ah, al, bh, bl));
        beats_sent++;
        if (op == FUNC_DIV && {bh, bl} == 128'd0)
            div_zero_seen++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Receiver stall pattern.
    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end

    // Check each accepted result beat.
    always @(posedge clk)
    begin
        alu_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat %h_%h", $time, res_high, res_low);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                beats_checked++;
                if (res_high !== want.res_high)
                begin
                    $display("%0t: res_high expected %h actual %h", $time, want.res_high, res_high);
                    error_count++;
                end
                if (res_low !== want.res_low)
                begin
                    $display("%0t: res_low expected %h actual %h", $time, want.res_low, res_low);
                    error_count++;
                end
                if (a_less !== want.less)
                begin
                    $display("%0t: a_less expected %b actual %b", $time, want.less, a_less);
                    error_count++;
                end
                if (a_equal !== want.equal)
                begin
                    $display("%0t: a_equal expected %b actual %b", $time, want.equal, a_equal);
                    error_count++;
                end
                if (divide_error !== want.div_err)
                begin
                    $display("%0t: divide_error expected %b actual %b", $time, want.div_err,
                             divide_error);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random 64-bit value biased toward edges and small magnitudes.
    function automatic logic [63:0] pick_half();
        case ($urandom_range(7, 0))
            0: return 64'd0;
            1: return '1;
            2: return {1'b1, 63'd0};
            3: return {1'b0, {63{1'b1}}};
            4: return 64'($urandom_range(15, 0));
            default: return rand64();
        endcase
    endfunction

    // Directed corners: extremes, every operation, divide by zero and overflow.
    task automatic test_corners();
        send_beat(FUNC_ADD, 64'd0, 64'd0, 64'd0, 64'd0);
        send_beat(FUNC_ADD, '1, '1, 64'd0, 64'd1);
        send_beat(FUNC_ADD, {1'b0, {63{1'b1}}}, '1, 64'd0, 64'd1);
        send_beat(FUNC_SUB, {1'b1, 63'd0}, 64'd0, 64'd0, 64'd1);
        send_beat(FUNC_SUB, 64'd5, 64'd7, 64'd5, 64'd7);
        send_beat(FUNC_MUL, '1, '1, '1, '1);
        send_beat(FUNC_MUL, {1'b0, {63{1'b1}}}, '1, {1'b0, {63{1'b1}}}, '1);
        send_beat(FUNC_MUL, 64'd0, '1, 64'd0, '1);
        send_beat(FUNC_DIV, 64'd3, 64'd9, 64'd0, 64'd0);
        send_beat(FUNC_DIV, 64'd0, 64'd0, 64'd0, 64'd0);
        send_beat(FUNC_DIV, {1'b1, 63'd0}, 64'd0, '1, '1);
        send_beat(FUNC_DIV, {1'b1, 63'd0}, 64'd0, 64'd0, 64'd1);
        send_beat(FUNC_DIV, '1, -64'd7, 64'd0, 64'd2);
        send_beat(FUNC_DIV, 64'd0, 64'd7, '1, -64'd2);
        send_beat(FUNC_DIV, 64'd0, 64'd3, 64'd0, 64'd9);
        send_beat(FUNC_DIV, {1'b0, {63{1'b1}}}, '1, {1'b1, 63'd0}, 64'd0);
        send_beat(FUNC_SUB, {1'b1, 63'd0}, 64'd0, {1'b0, {63{1'b1}}}, '1);
        send_beat(FUNC_ADD, {1'b0, {63{1'b1}}}, '1, {1'b1, 63'd0}, 64'd0);
    endtask

    // Random operand beats with edge-biased halves.
    task automatic test_random(int count);
        logic [63:0] bh;
        logic [63:0] bl;
        for (int i = 0; i < count; i++)
        begin
            bh = pick_half();
            bl = pick_half();
            if ($urandom_range(15, 0) == 0)
            begin
                bh = '0;
                bl = '0;
            end
            send_beat(func_t'($urandom_range(3, 0)), pick_half(), pick_half(), bh, bl);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * HW + 10) @(posedge clk);
    endtask

    // Timeout.
    initial
    begin
        #(12ns * 2000000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        func = FUNC_ADD;
        a_high = '0;
        a_low = '0;
        b_high = '0;
        b_low = '0;
        error_count = 0;
        beats_sent = 0;
        beats_checked = 0;
        div_zero_seen = 0;
        send_idle_pct = 35;
        recv_idle_pct = 82;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners();
        test_random(550);
        send_idle_pct = 82;
        recv_idle_pct = 35;
        test_random(550);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(600);
        wait_drained();
        $display("Checked %0d of %0d beats over all four operations, %0d divides by zero,",
                 beats_checked, beats_sent, div_zero_seen);
        $display("with sender and receiver gaps swapped and then removed.");
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
